### design/positional_list_store_unit_assert.svh
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// same-cycle check
`define PLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pls assertion failed");

// next-cycle check
`define PLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pls assertion failed");

`endif

### design/pls_pkg.sv
package pls_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MODE_W       = 3;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 6;

    typedef enum logic [MODE_W-1:0] {
        M_INS_FRONT = 3'd0,
        M_INS_BACK  = 3'd1,
        M_INS_POS   = 3'd2,
        M_DEL_FRONT = 3'd3,
        M_DEL_BACK  = 3'd4,
        M_DEL_POS   = 3'd5,
        M_DUMP      = 3'd6,
        M_COUNT     = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic accept;
        logic dump_step;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic dump_go;
        logic dump_last;
    } t_dp_status;

endpackage

### design/pls_if.sv
interface pls_cmd_if;
    import pls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface pls_rsp_if;
    import pls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last;

    modport source (output valid, status, entry_count, entry_value, last, input ready);
    modport sink   (input valid, status, entry_count, entry_value, last, output ready);
endinterface

### design/pls_ctrl.sv
module pls_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  pls_pkg::t_dp_status  i_stat,
    output pls_pkg::t_ctl_cmd    o_cmd
);
    import pls_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        slot_free  = !r_out_valid || i_out_ready;
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = slot_free;
                if (i_in_valid && slot_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.dump_go) begin
                        n_state = S_DUMP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    o_cmd.dump_step = 1'b1;
                    o_cmd.load      = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/pls_datapath.sv
module pls_datapath #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pls_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [pls_pkg::DATA_W-1:0] i_value,
    input  logic [pls_pkg::POS_W-1:0]         i_position,
    input  pls_pkg::t_ctl_cmd                 i_cmd,
    output pls_pkg::t_dp_status               o_stat,
    output logic [pls_pkg::STATUS_W-1:0]      o_status,
    output logic [pls_pkg::COUNT_W-1:0]       o_entry_count,
    output logic signed [pls_pkg::DATA_W-1:0] o_entry_value,
    output logic                              o_last
);
    import pls_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic signed [DATA_W-1:0] r_cell [CAPACITY];
    logic signed [DATA_W-1:0] n_cell [CAPACITY];
    logic [LW-1:0]            r_len, n_len;
    logic [LW-1:0]            r_dump_left, n_dump_left;
    t_status                  r_status;
    logic [COUNT_W-1:0]       r_count;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_last;

    t_mode         mode;
    t_status       status;
    logic          do_ins, do_del, is_full, is_empty;
    logic [IW-1:0] idx, rot_last;
    logic [CW-1:0] len_x, pos_x;

    always_comb begin
        mode     = t_mode'(i_mode);
        len_x    = CW'(r_len);
        pos_x    = CW'(i_position);
        is_full  = r_len >= LW'(CAPACITY);
        is_empty = r_len == '0;
        status   = STAT_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        idx      = '0;
        case (mode)
            M_INS_FRONT, M_INS_BACK: begin
                if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = (mode == M_INS_FRONT) ? '0 : IW'(r_len);
                end
            end
            M_INS_POS: begin
                if (pos_x == '0 || pos_x > len_x + CW'(1)) begin
                    status = STAT_BAD_POS;
                end else if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = IW'(pos_x - CW'(1));
                end
            end
            M_DEL_FRONT, M_DEL_BACK: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end else begin
                    do_del = 1'b1;
                    idx    = (mode == M_DEL_FRONT) ? '0 : IW'(len_x - CW'(1));
                end
            end
            M_DEL_POS: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end else if (pos_x == '0 || pos_x > len_x) begin
                    status = STAT_BAD_POS;
                end else begin
                    do_del = 1'b1;
                    idx    = IW'(pos_x - CW'(1));
                end
            end
            M_DUMP: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end
            end
            default: begin
                status = STAT_OK;
            end
        endcase
        o_stat.dump_go   = (mode == M_DUMP) && !is_empty;
        o_stat.dump_last = r_dump_left == LW'(1);
    end

    // cell row: shift for insert/delete, rotate within the live entries on dump
    always_comb begin
        rot_last = IW'(r_len - LW'(1));
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.accept && do_ins) begin
            for (int i = 1; i < CAPACITY; i++) begin
                if (IW'(i) > idx) begin
                    n_cell[i] = r_cell[i-1];
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (IW'(i) == idx) begin
                    n_cell[i] = i_value;
                end
            end
        end else if (i_cmd.accept && do_del) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IW'(i) >= idx) begin
                    n_cell[i] = r_cell[i+1];
                end
            end
        end else if (i_cmd.dump_step) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (IW'(i) == rot_last) begin
                    n_cell[i] = r_cell[0];
                end
            end
        end
    end

    always_comb begin
        n_len = r_len;
        if (i_cmd.accept && do_ins) begin
            n_len = r_len + LW'(1);
        end else if (i_cmd.accept && do_del) begin
            n_len = r_len - LW'(1);
        end
        n_dump_left = r_dump_left;
        if (i_cmd.accept && o_stat.dump_go) begin
            n_dump_left = r_len;
        end else if (i_cmd.dump_step) begin
            n_dump_left = r_dump_left - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_dump_left <= '0;
        end else begin
            r_len       <= n_len;
            r_dump_left <= n_dump_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.load) begin
            r_count <= COUNT_W'(n_len);
            if (i_cmd.dump_step) begin
                r_status <= STAT_OK;
                r_value  <= r_cell[0];
                r_last   <= o_stat.dump_last;
            end else begin
                r_status <= status;
                r_value  <= '0;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_entry_value = r_value;
    assign o_last        = r_last;

endmodule

### design/positional_list_store_unit.sv
// A non-dump result is registered and shows in the cycle after its command transfer.
// Throughput: one non-dump command per cycle while results are taken.
// A dump is first accepted, then loads its entries one at a time from the rotating
// cell row; no command is taken until the final entry is loaded.
// Reset (synchronous, active low) empties the list and clears the controller and
// output valid; the cell contents are not cleared.
module positional_list_store_unit #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pls_cmd_if.sink   i_cmd,
    pls_rsp_if.source o_rsp
);
    import pls_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status stat;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_cmd.mode),
        .i_value       (i_cmd.value),
        .i_position    (i_cmd.position),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count),
        .o_entry_value (o_rsp.entry_value),
        .o_last        (o_rsp.last)
    );

endmodule

### design/pls_checker.sv
`include "positional_list_store_unit_assert.svh"

module pls_checker #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cmd_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [pls_pkg::STATUS_W-1:0]      i_rsp_status,
    input logic [pls_pkg::COUNT_W-1:0]       i_rsp_count,
    input logic signed [pls_pkg::DATA_W-1:0] i_rsp_value,
    input logic                              i_rsp_last
);
    import pls_pkg::*;

    `PLS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, i_rsp_valid, i_rsp_count <= CAPACITY)
    `PLS_ASSERT_NOW(a_refused_single, i_clk, i_rst_n, i_rsp_valid && i_rsp_status != STAT_OK, i_rsp_last && i_rsp_value == '0)
    `PLS_ASSERT_NOW(a_no_cmd_in_dump, i_clk, i_rst_n, i_rsp_valid && !i_rsp_last, !i_cmd_ready)
    `PLS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_last) && $stable(i_rsp_status))

endmodule

bind positional_list_store_unit pls_checker #(
    .CAPACITY (CAPACITY)
) u_pls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_count  (o_rsp.entry_count),
    .i_rsp_value  (o_rsp.entry_value),
    .i_rsp_last   (o_rsp.last)
);
